[rtl/core/slik_pkg.sv]
// Shared types, constants and helper functions for the slew-limited arm kinematics block.
package slik_pkg;

    localparam int LEN_W     = 24;
    localparam int ANG_W     = 18;
    localparam int STEP_W    = 16;
    localparam int BASE_W    = 23;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 24;
    localparam int CW        = 44;
    localparam int ZW        = 28;
    localparam int MW        = 64;
    localparam int MUL_W     = 32;
    localparam int SQ_W      = 50;
    localparam int TAB_LEN   = 24;
    localparam int TAB_IDX_W = 5;

    localparam logic signed [ZW-1:0] QUARTER_TURN = 28'sd5898240;
    localparam logic signed [ZW-1:0] HALF_TURN    = 28'sd11796480;
    localparam logic signed [ZW-1:0] FULL_TURN    = 28'sd23592960;
    localparam logic signed [CW-1:0] GAIN_INV     = 44'sd10188014;
    localparam logic [SQ_W-1:0]      SQRT_BIT0    = 50'd1 << 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_X   = 3'd0,
        CFG_TARGET_Y   = 3'd1,
        CFG_STEP_X     = 3'd2,
        CFG_STEP_Y     = 3'd3,
        CFG_PIVOT      = 3'd4,
        CFG_SLIDE_BASE = 3'd5,
        CFG_SIDE_OFF   = 3'd6
    } cfg_idx_t;

    typedef enum logic {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } opcode_t;

    // atan(2^-i) in 2^-16 degree
    function automatic logic signed [ZW-1:0] atan_lut(input logic [TAB_IDX_W-1:0] i);
        logic signed [ZW-1:0] t;
        begin
            unique case (i)
                5'd0:  t = 28'sd2949120;
                5'd1:  t = 28'sd1740967;
                5'd2:  t = 28'sd919879;
                5'd3:  t = 28'sd466945;
                5'd4:  t = 28'sd234379;
                5'd5:  t = 28'sd117304;
                5'd6:  t = 28'sd58666;
                5'd7:  t = 28'sd29335;
                5'd8:  t = 28'sd14668;
                5'd9:  t = 28'sd7334;
                5'd10: t = 28'sd3667;
                5'd11: t = 28'sd1833;
                5'd12: t = 28'sd917;
                5'd13: t = 28'sd458;
                5'd14: t = 28'sd229;
                5'd15: t = 28'sd115;
                5'd16: t = 28'sd57;
                5'd17: t = 28'sd29;
                5'd18: t = 28'sd14;
                5'd19: t = 28'sd7;
                5'd20: t = 28'sd4;
                5'd21: t = 28'sd2;
                5'd22: t = 28'sd1;
                default: t = 28'sd0;
            endcase
            return t;
        end
    endfunction

    function automatic logic signed [LEN_W-1:0] sat_len(input logic signed [MW-1:0] v);
        logic signed [MW-1:0] hi;
        logic signed [MW-1:0] lo;
        begin
            hi = MW'((64'sd1 <<< (LEN_W - 1)) - 64'sd1);
            lo = -(64'sd1 <<< (LEN_W - 1));
            if (v > hi)
                return LEN_W'(hi);
            else if (v < lo)
                return LEN_W'(lo);
            else
                return LEN_W'(v);
        end
    endfunction

    function automatic logic signed [LEN_W-1:0] step_axis(
        input logic signed [LEN_W-1:0] cur,
        input logic signed [LEN_W-1:0] tgt,
        input logic [STEP_W-1:0]       step
    );
        logic signed [LEN_W:0] diff;
        logic signed [LEN_W:0] stp;
        begin
            diff = (LEN_W+1)'(tgt) - (LEN_W+1)'(cur);
            stp  = (LEN_W+1)'({1'b0, step});
            if (diff > stp)
                return LEN_W'((LEN_W+1)'(cur) + stp);
            else if (diff < -stp)
                return LEN_W'((LEN_W+1)'(cur) - stp);
            else
                return tgt;
        end
    endfunction

endpackage

[rtl/core/slew_limited_arm_inverse_kinematics.sv]
// Slew-limited arm inverse kinematics: sequencer around a shared CORDIC, multiplier and root unit.
//
// Input channel (in_valid/in_stall): opcode 0 starts from the measured slide extension and
// joint angle (forward kinematics), opcode 1 steps x and y toward the targets by at most one
// step each. Every transaction yields exactly one result transaction on out_valid/out_stall
// carrying the point, the slide and joint commands, and the unreachable flag.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce.
// One item at a time: in_stall is high from acceptance until the sequencer is back in idle.
// The time an item takes is set by the single CORDIC stage, which runs once for sin/cos on
// a start and twice for the two arctangents, and by the square-root loop. An unreachable
// point skips root and arctangents. The next item can be accepted in the cycle after the
// result is loaded.
// The four products of the forward step and the three squares share one 32x32 multiplier.
// The result sits in an output register; a new item is accepted while it waits, and the
// sequencer holds in its final state if the previous result is still stalled.
// Reset clears the point to the origin, the targets and offsets to zero and the steps to
// 1.0; no result is pending after reset.
module slew_limited_arm_inverse_kinematics #(
    parameter int CORDIC_ITERS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [slik_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  logic [slik_pkg::CFG_W-1:0]            cfg_wdata,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  opcode,
    input  logic signed [slik_pkg::LEN_W-1:0]     measured_slide,
    input  logic signed [slik_pkg::ANG_W-1:0]     measured_angle,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [slik_pkg::LEN_W-1:0]     pos_x,
    output logic signed [slik_pkg::LEN_W-1:0]     pos_y,
    output logic signed [slik_pkg::LEN_W-1:0]     slide_cmd,
    output logic signed [slik_pkg::ANG_W-1:0]     angle_cmd,
    output logic                                  unreachable
);
    import slik_pkg::*;

    localparam int IT_W = $clog2(CORDIC_ITERS + 1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_SC_FOLD, ST_SC_ITER,
        ST_FK_X1, ST_FK_X2, ST_FK_X3, ST_FK_Y1, ST_FK_Y2, ST_FK_Y3,
        ST_IK_DY, ST_IK_R1, ST_IK_R2, ST_IK_R3, ST_IK_R4,
        ST_SQRT, ST_AT_INIT, ST_AT_ITER, ST_AT_DONE, ST_FIN
    } state_t;

    state_t state_reg;

    logic signed [LEN_W-1:0]  target_x_reg, target_y_reg, pivot_reg, side_reg;
    logic [STEP_W-1:0]        step_x_reg, step_y_reg;
    logic [BASE_W-1:0]        base_reg;
    logic signed [LEN_W-1:0]  cur_x_reg, cur_y_reg, dy_reg;
    logic signed [LEN_W:0]    p_reg;
    logic signed [CW-1:0]     x_reg, y_reg;
    logic signed [ZW-1:0]     z_reg, phi_reg;
    logic                     flip_reg, phase_reg;
    logic [IT_W-1:0]          it_reg;
    logic signed [MW-1:0]     mul_reg, acc_reg;
    logic [SQ_W-1:0]          n_reg, res_reg, bit_reg;
    logic                     out_valid_reg, unreach_reg;
    logic signed [LEN_W-1:0]  pos_x_reg, pos_y_reg, slide_reg, slide_out_reg;
    logic signed [ANG_W-1:0]  angle_reg, angle_out_reg;
    logic                     unreach_out_reg;

    logic                     in_acc;
    logic signed [ZW-1:0]     th_in, th_red;
    logic signed [MUL_W-1:0]  mul_a, mul_b, cos_v, sin_v;
    logic signed [CW-1:0]     sh_x, sh_y, x_next, y_next;
    logic signed [ZW-1:0]     tab_v, z_next;
    logic                     rot_pos, it_last;
    logic signed [LEN_W+1:0]  at_vx, at_vy, h_val;
    logic signed [CW-1:0]     ax, ay;
    logic [SQ_W-1:0]          sq_trial;
    logic signed [ZW-1:0]     ang_sum;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign slide_cmd = slide_out_reg;
    assign angle_cmd = angle_out_reg;
    assign unreachable = unreach_out_reg;

    // start angle reduced to (-180, 180] degrees in 2^-16 degree
    always_comb
    begin
        th_in = ZW'(measured_angle) <<< 8;
        if (th_in > HALF_TURN)
            th_red = th_in - FULL_TURN;
        else if (th_in <= -HALF_TURN)
            th_red = th_in + FULL_TURN;
        else
            th_red = th_in;
    end

    assign cos_v = flip_reg ? MUL_W'(-x_reg) : MUL_W'(x_reg);
    assign sin_v = flip_reg ? MUL_W'(-y_reg) : MUL_W'(y_reg);

    always_comb
    begin
        unique case (state_reg)
            ST_FK_X1: begin mul_a = MUL_W'(p_reg);     mul_b = cos_v; end
            ST_FK_X2: begin mul_a = MUL_W'(side_reg);  mul_b = sin_v; end
            ST_FK_X3: begin mul_a = MUL_W'(p_reg);     mul_b = sin_v; end
            ST_FK_Y1: begin mul_a = MUL_W'(side_reg);  mul_b = cos_v; end
            ST_IK_R1: begin mul_a = MUL_W'(cur_x_reg); mul_b = MUL_W'(cur_x_reg); end
            ST_IK_R2: begin mul_a = MUL_W'(dy_reg);    mul_b = MUL_W'(dy_reg); end
            ST_IK_R3: begin mul_a = MUL_W'(side_reg);  mul_b = MUL_W'(side_reg); end
            default:  begin mul_a = '0;                mul_b = '0; end
        endcase
    end

    // shared CORDIC micro-rotation
    always_comb
    begin
        sh_x    = x_reg >>> it_reg;
        sh_y    = y_reg >>> it_reg;
        tab_v   = atan_lut(TAB_IDX_W'(it_reg));
        rot_pos = (state_reg == ST_SC_ITER) ? !z_reg[ZW-1] : !(y_reg > 0);
        x_next  = rot_pos ? x_reg - sh_y : x_reg + sh_y;
        y_next  = rot_pos ? y_reg + sh_x : y_reg - sh_x;
        z_next  = rot_pos ? z_reg - tab_v : z_reg + tab_v;
        it_last = (it_reg == IT_W'(CORDIC_ITERS - 1));
    end

    assign h_val = (LEN_W+2)'({1'b0, res_reg[LEN_W:0]});
    assign at_vx = phase_reg ? h_val : (LEN_W+2)'(cur_x_reg);
    assign at_vy = phase_reg ? (LEN_W+2)'(side_reg) : (LEN_W+2)'(dy_reg);
    assign ax    = CW'(at_vx) <<< 16;
    assign ay    = CW'(at_vy) <<< 16;
    assign sq_trial = res_reg + bit_reg;
    assign ang_sum  = phi_reg - z_reg + ZW'(128);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            target_x_reg    <= '0;
            target_y_reg    <= '0;
            step_x_reg      <= STEP_W'(256);
            step_y_reg      <= STEP_W'(256);
            pivot_reg       <= '0;
            base_reg        <= '0;
            side_reg        <= '0;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            dy_reg          <= '0;
            p_reg           <= '0;
            x_reg           <= '0;
            y_reg           <= '0;
            z_reg           <= '0;
            phi_reg         <= '0;
            flip_reg        <= 1'b0;
            phase_reg       <= 1'b0;
            it_reg          <= '0;
            mul_reg         <= '0;
            acc_reg         <= '0;
            n_reg           <= '0;
            res_reg         <= '0;
            bit_reg         <= '0;
            unreach_reg     <= 1'b0;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            slide_reg       <= '0;
            slide_out_reg   <= '0;
            angle_reg       <= '0;
            angle_out_reg   <= '0;
            unreach_out_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_TARGET_X:   target_x_reg <= cfg_wdata[LEN_W-1:0];
                    CFG_TARGET_Y:   target_y_reg <= cfg_wdata[LEN_W-1:0];
                    CFG_STEP_X:     step_x_reg   <= cfg_wdata[STEP_W-1:0];
                    CFG_STEP_Y:     step_y_reg   <= cfg_wdata[STEP_W-1:0];
                    CFG_PIVOT:      pivot_reg    <= cfg_wdata[LEN_W-1:0];
                    CFG_SLIDE_BASE: base_reg     <= cfg_wdata[BASE_W-1:0];
                    CFG_SIDE_OFF:   side_reg     <= cfg_wdata[LEN_W-1:0];
                    default: ;
                endcase
            end

            // in ST_FIN the output register is handled below
            if (out_valid_reg && !out_stall && state_reg != ST_FIN)
                out_valid_reg <= 1'b0;

            mul_reg <= mul_a * mul_b;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (opcode == OP_START)
                        begin
                            z_reg     <= th_red;
                            p_reg     <= (LEN_W+1)'({1'b0, base_reg})
                                       + (LEN_W+1)'(measured_slide);
                            state_reg <= ST_SC_FOLD;
                        end
                        else
                        begin
                            cur_x_reg <= step_axis(cur_x_reg, target_x_reg, step_x_reg);
                            cur_y_reg <= step_axis(cur_y_reg, target_y_reg, step_y_reg);
                            state_reg <= ST_IK_DY;
                        end
                    end
                end
                ST_SC_FOLD:
                begin
                    x_reg  <= GAIN_INV;
                    y_reg  <= '0;
                    it_reg <= '0;
                    if (z_reg > QUARTER_TURN)
                    begin
                        z_reg    <= z_reg - HALF_TURN;
                        flip_reg <= 1'b1;
                    end
                    else if (z_reg < -QUARTER_TURN)
                    begin
                        z_reg    <= z_reg + HALF_TURN;
                        flip_reg <= 1'b1;
                    end
                    else
                        flip_reg <= 1'b0;
                    state_reg <= ST_SC_ITER;
                end
                ST_SC_ITER:
                begin
                    x_reg  <= x_next;
                    y_reg  <= y_next;
                    z_reg  <= z_next;
                    it_reg <= it_reg + 1'b1;
                    if (it_last)
                        state_reg <= ST_FK_X1;
                end
                ST_FK_X1: state_reg <= ST_FK_X2;
                ST_FK_X2:
                begin
                    acc_reg   <= mul_reg;
                    state_reg <= ST_FK_X3;
                end
                ST_FK_X3:
                begin
                    acc_reg   <= acc_reg - mul_reg + (64'sd1 <<< 23);
                    state_reg <= ST_FK_Y1;
                end
                ST_FK_Y1:
                begin
                    cur_x_reg <= sat_len(acc_reg >>> 24);
                    acc_reg   <= mul_reg;
                    state_reg <= ST_FK_Y2;
                end
                ST_FK_Y2:
                begin
                    acc_reg   <= acc_reg + mul_reg + (64'sd1 <<< 23);
                    state_reg <= ST_FK_Y3;
                end
                ST_FK_Y3:
                begin
                    cur_y_reg <= sat_len((acc_reg >>> 24) + MW'(pivot_reg));
                    state_reg <= ST_IK_DY;
                end
                ST_IK_DY:
                begin
                    dy_reg    <= sat_len(MW'(cur_y_reg) - MW'(pivot_reg));
                    state_reg <= ST_IK_R1;
                end
                ST_IK_R1: state_reg <= ST_IK_R2;
                ST_IK_R2:
                begin
                    acc_reg   <= mul_reg;
                    state_reg <= ST_IK_R3;
                end
                ST_IK_R3:
                begin
                    acc_reg   <= acc_reg + mul_reg;
                    state_reg <= ST_IK_R4;
                end
                ST_IK_R4:
                begin
                    if (mul_reg > acc_reg)
                    begin
                        unreach_reg <= 1'b1;
                        slide_reg   <= '0;
                        angle_reg   <= '0;
                        state_reg   <= ST_FIN;
                    end
                    else
                    begin
                        unreach_reg <= 1'b0;
                        n_reg       <= SQ_W'(acc_reg - mul_reg);
                        res_reg     <= '0;
                        bit_reg     <= SQRT_BIT0;
                        state_reg   <= ST_SQRT;
                    end
                end
                ST_SQRT:
                begin
                    if (bit_reg == '0)
                    begin
                        phase_reg <= 1'b0;
                        state_reg <= ST_AT_INIT;
                    end
                    else
                    begin
                        if (n_reg >= sq_trial)
                        begin
                            n_reg   <= n_reg - sq_trial;
                            res_reg <= (res_reg >> 1) + bit_reg;
                        end
                        else
                            res_reg <= res_reg >> 1;
                        bit_reg <= bit_reg >> 2;
                    end
                end
                ST_AT_INIT:
                begin
                    it_reg <= '0;
                    if (at_vx == '0 && at_vy == '0)
                    begin
                        z_reg     <= '0;
                        state_reg <= ST_AT_DONE;
                    end
                    else
                    begin
                        if (ax < 0 && ay >= 0)
                        begin
                            x_reg <= ay;
                            y_reg <= -ax;
                            z_reg <= QUARTER_TURN;
                        end
                        else if (ax < 0)
                        begin
                            x_reg <= -ay;
                            y_reg <= ax;
                            z_reg <= -QUARTER_TURN;
                        end
                        else
                        begin
                            x_reg <= ax;
                            y_reg <= ay;
                            z_reg <= '0;
                        end
                        state_reg <= ST_AT_ITER;
                    end
                end
                ST_AT_ITER:
                begin
                    x_reg  <= x_next;
                    y_reg  <= y_next;
                    z_reg  <= z_next;
                    it_reg <= it_reg + 1'b1;
                    if (it_last)
                        state_reg <= ST_AT_DONE;
                end
                ST_AT_DONE:
                begin
                    if (!phase_reg)
                    begin
                        phi_reg   <= z_reg;
                        phase_reg <= 1'b1;
                        state_reg <= ST_AT_INIT;
                    end
                    else
                    begin
                        slide_reg <= sat_len(MW'(h_val) - MW'({1'b0, base_reg}));
                        angle_reg <= ang_sum[ANG_W+7:8];
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        pos_x_reg       <= cur_x_reg;
                        pos_y_reg       <= cur_y_reg;
                        slide_out_reg   <= slide_reg;
                        angle_out_reg   <= angle_reg;
                        unreach_out_reg <= unreach_reg;
                        out_valid_reg   <= 1'b1;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unreachable |-> slide_cmd == '0 && angle_cmd == '0)
        else $error("unreachable result carries nonzero commands");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg != ST_IDLE)
        else $error("sequencer did not leave idle after a transaction");

    a_sqrt_bit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SQRT |-> $onehot0(bit_reg))
        else $error("square-root trial bit corrupted");

    a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN && !out_valid |=> out_valid && state_reg == ST_IDLE)
        else $error("finished result not loaded into output register");

endmodule

[tb/slew_limited_arm_inverse_kinematics_tb.sv]
// Testbench for the slew-limited arm inverse kinematics block: randomized transactions checked against a behavioral predictor.
module slew_limited_arm_inverse_kinematics_tb;
    import slik_pkg::*;

    localparam int ITERS     = 16;
    localparam int WDOG_MAX  = 20000;
    localparam int SETTLE    = 200;

    typedef struct packed {
        opcode_t                  op;
        logic signed [LEN_W-1:0]  slide;
        logic signed [ANG_W-1:0]  angle;
    } pose_req_t;

    typedef struct packed {
        logic signed [LEN_W-1:0]  px;
        logic signed [LEN_W-1:0]  py;
        logic signed [LEN_W-1:0]  slide;
        logic signed [ANG_W-1:0]  angle;
        logic                     unr;
    } joint_cmd_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic opcode = 1'b0;
    logic signed [LEN_W-1:0] measured_slide = '0;
    logic signed [ANG_W-1:0] measured_angle = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [LEN_W-1:0] pos_x, pos_y, slide_cmd;
    logic signed [ANG_W-1:0] angle_cmd;
    logic unreachable;

    slew_limited_arm_inverse_kinematics #(.CORDIC_ITERS(ITERS)) u_top (.*);

    always #4 clk = ~clk;

    // predictor state
    longint tgt_x, tgt_y, stp_x, stp_y, piv_a, base_b, off_d, pt_x, pt_y;
    longint atan_q16[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

    pose_req_t  pending_q[$];
    joint_cmd_t expected_q[$];
    int errors = 0;
    int wdog = 0;
    bit drain_req = 0;

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp_len(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint root64(longint n);
        longint r = 0;
        longint b = 64'sd1 <<< 62;
        while (b > n) b = b >>> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >>> 1) + b;
            end else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint vec_angle(longint vy, longint vx);
        longint x, y, z, t, dx, dy;
        x = vx * 65536;
        y = vy * 65536;
        z = 0;
        if (vx == 0 && vy == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin t = x; x = y; y = -t; z = 5898240; end
            else begin t = x; x = -y; y = t; z = -5898240; end
        end
        for (int i = 0; i < ITERS; i++) begin
            dx = shr(x, i);
            dy = shr(y, i);
            if (y > 0) begin x += dy; y -= dx; z += atan_q16[i]; end
            else begin x -= dy; y += dx; z -= atan_q16[i]; end
        end
        return z;
    endfunction

    task automatic rotate(input longint zin, output longint c, output longint s);
        longint x, y, z, dx, dy;
        bit flip;
        x = 10188014;
        y = 0;
        flip = 0;
        z = ((zin % 23592960) + 23592960) % 23592960;
        if (z > 11796480) z -= 23592960;
        if (z > 5898240) begin z -= 11796480; flip = 1; end
        else if (z < -5898240) begin z += 11796480; flip = 1; end
        for (int i = 0; i < ITERS; i++) begin
            dx = shr(x, i);
            dy = shr(y, i);
            if (z >= 0) begin x -= dy; y += dx; z -= atan_q16[i]; end
            else begin x += dy; y -= dx; z += atan_q16[i]; end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint slew(longint c, longint t, longint s);
        if (t - c > s) return c + s;
        if (t - c < -s) return c - s;
        return t;
    endfunction

    task automatic predict_pose(input pose_req_t rq);
        longint p, c, s, dy, r2, d2, h, phi, alpha, sl, an;
        joint_cmd_t e;
        bit unr;
        if (rq.op == OP_START) begin
            p = base_b + longint'(rq.slide);
            rotate(longint'(rq.angle) * 256, c, s);
            pt_x = clamp_len(shr(p * c - off_d * s + (64'sd1 <<< 23), 24));
            pt_y = clamp_len(shr(p * s + off_d * c + (64'sd1 <<< 23), 24) + piv_a);
        end else begin
            pt_x = slew(pt_x, tgt_x, stp_x);
            pt_y = slew(pt_y, tgt_y, stp_y);
        end
        dy = clamp_len(pt_y - piv_a);
        r2 = pt_x * pt_x + dy * dy;
        d2 = off_d * off_d;
        unr = d2 > r2;
        sl = 0;
        an = 0;
        if (!unr) begin
            h = root64(r2 - d2);
            phi = vec_angle(dy, pt_x);
            alpha = vec_angle(off_d, h);
            sl = clamp_len(h - base_b);
            an = shr(phi - alpha + 128, 8);
        end
        e.px = pt_x[LEN_W-1:0];
        e.py = pt_y[LEN_W-1:0];
        e.slide = sl[LEN_W-1:0];
        e.angle = an[ANG_W-1:0];
        e.unr = unr;
        expected_q.push_back(e);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input longint v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v[CFG_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_TARGET_X:   tgt_x = longint'($signed(v[23:0]));
            CFG_TARGET_Y:   tgt_y = longint'($signed(v[23:0]));
            CFG_STEP_X:     stp_x = v & 16'hFFFF;
            CFG_STEP_Y:     stp_y = v & 16'hFFFF;
            CFG_PIVOT:      piv_a = longint'($signed(v[23:0]));
            CFG_SLIDE_BASE: base_b = v & 23'h7FFFFF;
            default:        off_d = longint'($signed(v[23:0]));
        endcase
    endtask

    task automatic wait_idle;
        while (pending_q.size() != 0 || expected_q.size() != 0 || in_valid) @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    function automatic longint rand_len(int mag);
        longint v = longint'($urandom_range(0, mag));
        return $urandom_range(0, 1) ? v : -v;
    endfunction

    function automatic pose_req_t rand_req(bit tick_bias);
        pose_req_t r;
        r.op = ($urandom_range(0, 99) < (tick_bias ? 80 : 30)) ? OP_TICK : OP_START;
        case ($urandom_range(0, 3))
            0: r.slide = LEN_W'($urandom);
            default: r.slide = LEN_W'(rand_len(40000));
        endcase
        case ($urandom_range(0, 4))
            0: r.angle = ANG_W'($urandom);
            default: r.angle = ANG_W'(rand_len(92160));
        endcase
        return r;
    endfunction

    function automatic pose_req_t mk(opcode_t op, longint s, longint a);
        pose_req_t r;
        r.op = op;
        r.slide = s[LEN_W-1:0];
        r.angle = a[ANG_W-1:0];
        return r;
    endfunction

    function automatic int gap_len;
        return ($urandom_range(0, 9) == 0) ? int'($urandom_range(5, 60))
                                            : int'($urandom_range(0, 2));
    endfunction

    int in_gap = 0;
    int gap_pick = 0;
    bit calm = 0;
    bit in_stall_s = 1'b1;

    // driver
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall_s) begin
                if (gap_pick > 0 || pending_q.size() == 0 || drain_req) begin
                    in_valid <= 1'b0;
                    in_gap <= gap_pick;
                end else begin
                    opcode <= pending_q[0].op;
                    measured_slide <= pending_q[0].slide;
                    measured_angle <= pending_q[0].angle;
                    predict_pose(pending_q.pop_front());
                end
            end else if (!in_valid && in_gap > 0) begin
                in_gap <= in_gap - 1;
            end else if (!in_valid && pending_q.size() != 0 && !drain_req) begin
                in_valid <= 1'b1;
                opcode <= pending_q[0].op;
                measured_slide <= pending_q[0].slide;
                measured_angle <= pending_q[0].angle;
                predict_pose(pending_q.pop_front());
            end
            if (!calm)
                out_stall <= ($urandom_range(0, 9) < 3) ? 1'b1 : 1'b0;
            else
                out_stall <= 1'b0;
        end
    end

    // acceptance sampled at the rising edge
    always @(posedge clk) begin
        if (in_valid && !in_stall) begin
            in_stall_s <= 1'b0;
            gap_pick <= calm ? 0 : gap_len();
        end else
            in_stall_s <= 1'b1;
    end

    // monitor
    always @(posedge clk) begin
        joint_cmd_t e;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                wdog <= 0;
                if (expected_q.size() == 0) begin
                    $error("unexpected result transaction");
                    errors++;
                end else begin
                    e = expected_q.pop_front();
                    if (pos_x !== e.px) begin
                        $error("pos_x expected %0d actual %0d", e.px, pos_x); errors++;
                    end
                    if (pos_y !== e.py) begin
                        $error("pos_y expected %0d actual %0d", e.py, pos_y); errors++;
                    end
                    if (slide_cmd !== e.slide) begin
                        $error("slide_cmd expected %0d actual %0d", e.slide, slide_cmd);
                        errors++;
                    end
                    if (angle_cmd !== e.angle) begin
                        $error("angle_cmd expected %0d actual %0d", e.angle, angle_cmd);
                        errors++;
                    end
                    if (unreachable !== e.unr) begin
                        $error("unreachable expected %0d actual %0d", e.unr, unreachable);
                        errors++;
                    end
                end
            end else if (in_valid && !in_stall)
                wdog <= 0;
            else if (wdog >= WDOG_MAX) begin
                $display("Simulation FAILED");
                $finish;
            end else
                wdog <= wdog + 1;
        end
    end

    initial begin
        tgt_x = 0; tgt_y = 0; stp_x = 256; stp_y = 256;
        piv_a = 0; base_b = 0; off_d = 0; pt_x = 0; pt_y = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: default config, point on pivot, extremes of the inputs
        pending_q.push_back(mk(OP_TICK, 0, 0));
        pending_q.push_back(mk(OP_START, 0, 0));
        pending_q.push_back(mk(OP_START, 8388607, 92160));
        pending_q.push_back(mk(OP_START, -8388608, -92160));
        pending_q.push_back(mk(OP_START, 25600, 131071));
        pending_q.push_back(mk(OP_START, 25600, -131072));
        pending_q.push_back(mk(OP_START, 12800, 23040));
        pending_q.push_back(mk(OP_START, 12800, 46080));
        pending_q.push_back(mk(OP_START, -12800, -46080));
        wait_idle();

        write_reg(CFG_TARGET_X, 8388607);
        write_reg(CFG_TARGET_Y, -8388608);
        write_reg(CFG_STEP_X, 65535);
        write_reg(CFG_STEP_Y, 0);
        write_reg(CFG_PIVOT, 8388607);
        write_reg(CFG_SLIDE_BASE, 8388607);
        write_reg(CFG_SIDE_OFF, -8388608);
        pending_q.push_back(mk(OP_START, 0, 0));
        pending_q.push_back(mk(OP_TICK, 0, 0));
        pending_q.push_back(mk(OP_START, -8388608, 92160));
        pending_q.push_back(mk(OP_TICK, -1, -1));
        wait_idle();

        write_reg(CFG_PIVOT, -8388608);
        write_reg(CFG_SLIDE_BASE, 0);
        write_reg(CFG_SIDE_OFF, 2560);
        write_reg(CFG_STEP_Y, 65535);
        write_reg(CFG_TARGET_X, 0);
        write_reg(CFG_TARGET_Y, 0);
        pending_q.push_back(mk(OP_START, 100, 0));
        pending_q.push_back(mk(OP_TICK, 0, 0));
        pending_q.push_back(mk(OP_TICK, 0, 0));
        pending_q.push_back(mk(OP_START, 0, 0));
        wait_idle();

        // random phases with fresh settings
        for (int ph = 0; ph < 14; ph++) begin
            calm = (ph % 5 == 4);
            write_reg(CFG_TARGET_X, ($urandom_range(0, 5) == 0) ? longint'($urandom)
                                                                 : rand_len(60000));
            write_reg(CFG_TARGET_Y, ($urandom_range(0, 5) == 0) ? longint'($urandom)
                                                                 : rand_len(60000));
            write_reg(CFG_STEP_X, ($urandom_range(0, 3) == 0) ? longint'($urandom)
                                                               : longint'($urandom_range(0, 3000)));
            write_reg(CFG_STEP_Y, ($urandom_range(0, 3) == 0) ? longint'($urandom)
                                                               : longint'($urandom_range(0, 3000)));
            write_reg(CFG_PIVOT, ($urandom_range(0, 5) == 0) ? longint'($urandom)
                                                              : rand_len(20000));
            write_reg(CFG_SLIDE_BASE, ($urandom_range(0, 5) == 0) ? longint'($urandom)
                                                                   : longint'($urandom_range(0, 20000)));
            write_reg(CFG_SIDE_OFF, ($urandom_range(0, 5) == 0) ? longint'($urandom)
                                                                 : rand_len(8000));
            for (int k = 0; k < 72; k++)
                pending_q.push_back(rand_req(bit'(ph % 2)));
            if (ph == 7) begin
                while (pending_q.size() > 36) @(negedge clk);
                drain_req = 1;
                while (expected_q.size() != 0 || in_valid) @(negedge clk);
                drain_req = 0;
            end
            wait_idle();
        end
        calm = 0;

        while (expected_q.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

[filelist.f]
rtl/core/slik_pkg.sv
rtl/core/slew_limited_arm_inverse_kinematics.sv
tb/slew_limited_arm_inverse_kinematics_tb.sv
